[rtl/g2l_pkg.sv]
`default_nettype none

package g2l_pkg;

    localparam int YEAR_W  = 12;
    localparam int ENTRY_W = 30;
    localparam int ACC_W   = 22;
    localparam int P365_W  = 21;
    localparam int Q100_W  = 6;
    localparam int DOY_W   = 9;
    localparam int LEN_W   = 5;
    localparam int SB_W    = 13;
    localparam int SBQ_W   = 9;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [LEN_W-1:0] SHORT_MONTH_DAYS = 5'd29;
    localparam logic [SB_W-1:0]  SB_OFFSET        = 13'd56;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK1,
        S_CHK2,
        S_TERM,
        S_ACC,
        S_NYCHK,
        S_BACK,
        S_WALK,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_DATE   = 3'd1,
        ERR_MINUTE = 3'd2,
        ERR_HOUR   = 3'd3,
        ERR_BEFORE = 3'd4,
        ERR_NEG    = 3'd5,
        ERR_OVF    = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        SEL_P365,
        SEL_YQ4,
        SEL_Q100,
        SEL_Q400,
        SEL_DOY,
        SEL_LEN
    } t_alu_sel;

    typedef struct packed {
        t_alu_sel sel;
        logic     sub;
    } t_alu_req;

    typedef struct packed {
        logic [P365_W-1:0] p365;
        logic [YEAR_W-1:0] ty;
        logic [Q100_W-1:0] tq;
        logic [DOY_W-1:0]  doy;
        logic [LEN_W-1:0]  len;
    } t_terms;

    function automatic logic [DOY_W-1:0] doy_tab(input logic [3:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] mlen(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [24:0] p;
        p = 25'(y) * 25'd5243;
        return p[24:19];
    endfunction

    function automatic logic [SBQ_W-1:0] div10(input logic [SB_W-1:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd6554;
        return p[24:16];
    endfunction

    function automatic logic [SBQ_W-1:0] div12(input logic [SB_W-1:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd5462;
        return p[24:16];
    endfunction

endpackage

`default_nettype wire

[rtl/gregorian_to_lunar_date.sv]
// Convert: the result follows the input checks, the day-count terms and the month walk;
// a date that falls before the new year of its own year repeats the terms for the year
// before. Input check errors and table errors end the sequence at the failing step.
// One convert at a time: the next transaction is accepted in the cycle after the
// result loads; a stalled result holds the sequencer. Loads produce no result.
// Synchronous active-low reset clears the sequencer; table undefined until loaded.
`default_nettype none

module gregorian_to_lunar_date #(
    parameter int FIRST_YEAR = 1901,
    parameter int YEAR_COUNT = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [3:0]  i_new_year_month,
    input  logic [4:0]  i_new_year_day,
    input  logic [12:0] i_long_month_mask,
    input  logic [3:0]  i_leap_slot,
    input  logic [3:0]  i_month_total,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [2:0]  o_error_code,
    output logic [11:0] o_lunar_year,
    output logic [3:0]  o_lunar_month,
    output logic        o_is_leap_month,
    output logic [4:0]  o_lunar_day,
    output logic [3:0]  o_year_stem,
    output logic [3:0]  o_year_branch,
    output logic [3:0]  o_hr_branch
);

    import g2l_pkg::*;

    localparam int AW = $clog2(YEAR_COUNT);
    localparam logic [12:0] LP_FIRST = 13'(FIRST_YEAR);
    localparam logic [12:0] LP_LAST  = 13'(FIRST_YEAR + YEAR_COUNT - 1);

    t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_day, n_day;
    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_minute, n_minute;
    logic [YEAR_W-1:0] r_ly, n_ly;
    logic [Q100_W-1:0] r_cq, n_cq;
    logic              r_phase_ny, n_phase_ny;
    logic              r_back, n_back;
    t_alu_sel          r_sel, n_sel;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_dd, n_dd;
    logic [YEAR_W-1:0] r_ty, n_ty;
    logic [P365_W-1:0] r_p365, n_p365;
    logic [Q100_W-1:0] r_tq, n_tq;
    logic [DOY_W-1:0]  r_doy, n_doy;
    logic [3:0]        r_seq, n_seq;
    t_err              r_err, n_err;
    logic [3:0]        r_lm, n_lm;
    logic              r_il, n_il;
    logic [4:0]        r_lday, n_lday;
    logic [3:0]        r_hb, n_hb;
    logic              r_out_ok;
    t_err              r_out_err;
    logic [11:0]       r_out_year;
    logic [3:0]        r_out_month;
    logic              r_out_leap;
    logic [4:0]        r_out_day;
    logic [3:0]        r_out_stem;
    logic [3:0]        r_out_branch;
    logic [3:0]        r_out_hb;
    logic              w_out_load;
    logic [SBQ_W-1:0]  r_q10, r_q12;
    logic [3:0]        r_stem, r_branch;

    logic              w_in_acc;
    logic              w_load_in_range;
    logic [12:0]       w_widx_full, w_ridx_full;
    logic [ENTRY_W-1:0] w_wdata, w_entry;
    logic [3:0]        w_ny_m;
    logic [4:0]        w_ny_d;
    logic [12:0]       w_mask;
    logic [15:0]       w_mask16;
    logic [3:0]        w_leap;
    logic [3:0]        w_total;
    logic [3:0]        w_tm;
    logic [4:0]        w_td;
    logic [YEAR_W-1:0] w_ty;
    logic [3:0]        w_mp;
    logic [12:0]       w_c100;
    logic              w_gleap;
    logic              w_date_bad;
    logic              w_min_ok;
    logic [3:0]        w_hb;
    logic [SB_W-1:0]   w_sbx;
    t_alu_req          w_req;
    t_terms            w_terms;
    logic [ACC_W-1:0]  w_res;

    assign w_in_acc        = i_in_valid && !o_in_stall;
    assign w_load_in_range = ({1'b0, i_year} >= LP_FIRST) && ({1'b0, i_year} <= LP_LAST);
    assign w_widx_full     = {1'b0, i_year} - LP_FIRST;
    assign w_ridx_full     = {1'b0, r_ly} - LP_FIRST;
    assign w_wdata = {i_month_total, i_leap_slot, i_long_month_mask,
                      i_new_year_day, i_new_year_month};

    g2l_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(YEAR_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_in_acc && (i_op == OP_LOAD) && w_load_in_range),
        .i_waddr(w_widx_full[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_ridx_full[AW-1:0]),
        .o_rdata(w_entry)
    );

    assign w_ny_m   = w_entry[3:0];
    assign w_ny_d   = w_entry[8:4];
    assign w_mask   = w_entry[21:9];
    assign w_leap   = w_entry[25:22];
    assign w_total  = w_entry[29:26];
    assign w_mask16 = {3'b000, w_mask};

    assign w_tm = r_phase_ny ? w_ny_m : r_month;
    assign w_td = r_phase_ny ? w_ny_d : r_day;
    assign w_ty = (w_tm <= 4'd2) ? (r_ly - 12'd1) : r_ly;
    assign w_mp = (w_tm > 4'd2) ? (w_tm - 4'd3) : (w_tm + 4'd9);

    assign w_c100     = 13'(r_cq) * 13'd100;
    assign w_gleap    = (r_year[1:0] == 2'b00) &&
                        ((w_c100 != {1'b0, r_year}) || (r_cq[1:0] == 2'b00));
    assign w_date_bad = ({1'b0, r_year} < LP_FIRST) || ({1'b0, r_year} > LP_LAST) ||
                        (r_day == 5'd0) || (r_day > mlen(r_month, w_gleap));

    always_comb begin
        case (r_minute) inside
            6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25,
            6'd30, 6'd35, 6'd40, 6'd45, 6'd50, 6'd55: w_min_ok = 1'b1;
            default:                                   w_min_ok = 1'b0;
        endcase
    end

    assign w_hb = ((r_hour == 5'd23) || (r_hour == 5'd0)) ? 4'd0 :
                  4'((6'(r_hour) + 6'd1) >> 1);

    assign w_sbx = 13'(r_ly) + SB_OFFSET;

    always_ff @(posedge i_clk) begin
        r_q10    <= div10(w_sbx);
        r_q12    <= div12(w_sbx);
        r_stem   <= 4'(w_sbx - 13'(r_q10) * 13'd10);
        r_branch <= 4'(w_sbx - 13'(r_q12) * 13'd12);
    end

    assign w_terms.p365 = r_p365;
    assign w_terms.ty   = r_ty;
    assign w_terms.tq   = r_tq;
    assign w_terms.doy  = r_doy;
    assign w_terms.len  = SHORT_MONTH_DAYS + LEN_W'(w_mask16[r_seq]);

    always_comb begin
        if (r_state == S_ACC) begin
            w_req.sel = r_sel;
            w_req.sub = r_phase_ny ^ (r_sel == SEL_Q100);
        end else begin
            w_req.sel = SEL_LEN;
            w_req.sub = 1'b1;
        end
    end

    g2l_alu u_alu (
        .i_req  (w_req),
        .i_terms(w_terms),
        .i_acc  (r_acc),
        .o_res  (w_res)
    );

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state    = r_state;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_ly       = r_ly;
        n_cq       = r_cq;
        n_phase_ny = r_phase_ny;
        n_back     = r_back;
        n_sel      = r_sel;
        n_acc      = r_acc;
        n_dd       = r_dd;
        n_ty       = r_ty;
        n_p365     = r_p365;
        n_tq       = r_tq;
        n_doy      = r_doy;
        n_seq      = r_seq;
        n_err      = r_err;
        n_lm       = r_lm;
        n_il       = r_il;
        n_lday     = r_lday;
        n_hb       = r_hb;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_op == OP_CONVERT)) begin
                    n_year     = i_year;
                    n_month    = i_month;
                    n_day      = i_day;
                    n_hour     = i_hour;
                    n_minute   = i_minute;
                    n_ly       = i_year;
                    n_acc      = '0;
                    n_phase_ny = 1'b0;
                    n_back     = 1'b0;
                    n_sel      = SEL_P365;
                    n_state    = S_CHK1;
                end
            end
            S_CHK1: begin
                n_cq    = div100(r_year);
                n_state = S_CHK2;
            end
            S_CHK2: begin
                n_hb = 4'd0;
                if (w_date_bad) begin
                    n_err   = ERR_DATE;
                    n_state = S_DONE;
                end else if (!w_min_ok) begin
                    n_err   = ERR_MINUTE;
                    n_state = S_DONE;
                end else if (r_hour > 5'd23) begin
                    n_err   = ERR_HOUR;
                    n_state = S_DONE;
                end else begin
                    n_hb    = w_hb;
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                n_ty    = w_ty;
                n_p365  = P365_W'(w_ty) * P365_W'(365);
                n_tq    = div100(w_ty);
                n_doy   = doy_tab(w_mp) + DOY_W'(w_td);
                n_sel   = SEL_P365;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = w_res;
                case (r_sel)
                    SEL_P365: n_sel = SEL_YQ4;
                    SEL_YQ4:  n_sel = SEL_Q100;
                    SEL_Q100: n_sel = SEL_Q400;
                    SEL_Q400: n_sel = SEL_DOY;
                    default: begin
                        if (r_phase_ny) begin
                            n_state = S_NYCHK;
                        end else begin
                            n_dd       = w_res;
                            n_phase_ny = 1'b1;
                            n_state    = S_TERM;
                        end
                    end
                endcase
            end
            S_NYCHK: begin
                n_seq = '0;
                if (r_acc[ACC_W-1]) begin
                    if (r_back) begin
                        n_err   = ERR_NEG;
                        n_state = S_DONE;
                    end else if ({1'b0, r_ly} == LP_FIRST) begin
                        n_err   = ERR_BEFORE;
                        n_state = S_DONE;
                    end else begin
                        n_ly    = r_ly - 12'd1;
                        n_back  = 1'b1;
                        n_acc   = r_dd;
                        n_state = S_BACK;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_BACK: begin
                n_state = S_TERM;
            end
            S_WALK: begin
                if (r_seq >= w_total) begin
                    n_err   = ERR_OVF;
                    n_state = S_DONE;
                end else if (w_res[ACC_W-1]) begin
                    if ((w_leap != 4'd0) && (r_seq == w_leap)) begin
                        n_lm = w_leap;
                        n_il = 1'b1;
                    end else if ((w_leap != 4'd0) && (r_seq > w_leap)) begin
                        n_lm = r_seq;
                        n_il = 1'b0;
                    end else begin
                        n_lm = r_seq + 4'd1;
                        n_il = 1'b0;
                    end
                    n_lday  = r_acc[4:0] + 5'd1;
                    n_err   = ERR_NONE;
                    n_state = S_DONE;
                end else begin
                    n_acc = w_res;
                    n_seq = r_seq + 4'd1;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase_ny  <= 1'b0;
            r_back      <= 1'b0;
            r_sel       <= SEL_P365;
            r_seq       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase_ny  <= n_phase_ny;
            r_back      <= n_back;
            r_sel       <= n_sel;
            r_seq       <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_ly     <= n_ly;
        r_cq     <= n_cq;
        r_acc    <= n_acc;
        r_dd     <= n_dd;
        r_ty     <= n_ty;
        r_p365   <= n_p365;
        r_tq     <= n_tq;
        r_doy    <= n_doy;
        r_err    <= n_err;
        r_lm     <= n_lm;
        r_il     <= n_il;
        r_lday   <= n_lday;
        r_hb     <= n_hb;
        if (w_out_load) begin
            r_out_ok     <= (r_err == ERR_NONE);
            r_out_err    <= r_err;
            r_out_year   <= (r_err == ERR_NONE) ? r_ly : '0;
            r_out_month  <= (r_err == ERR_NONE) ? r_lm : '0;
            r_out_leap   <= (r_err == ERR_NONE) ? r_il : 1'b0;
            r_out_day    <= (r_err == ERR_NONE) ? r_lday : '0;
            r_out_stem   <= (r_err == ERR_NONE) ? r_stem : '0;
            r_out_branch <= (r_err == ERR_NONE) ? r_branch : '0;
            r_out_hb     <= r_hb;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_error_code    = r_out_err;
    assign o_lunar_year    = r_out_year;
    assign o_lunar_month   = r_out_month;
    assign o_is_leap_month = r_out_leap;
    assign o_lunar_day     = r_out_day;
    assign o_year_stem     = r_out_stem;
    assign o_year_branch   = r_out_branch;
    assign o_hr_branch     = r_out_hb;

    a_convert_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == OP_CONVERT)) |=> (r_state == S_CHK1))
        else $error("convert transaction did not start the check sequence");

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (!r_acc[ACC_W-1] && (r_seq <= w_total)))
        else $error("month walk out of bounds");

    a_ok_has_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> ((o_lunar_day != 5'd0) && (o_error_code == ERR_NONE)))
        else $error("successful result without lunar day");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == OP_LOAD)) |=> (r_state == S_IDLE))
        else $error("load transaction started a conversion");

endmodule

`default_nettype wire

[rtl/g2l_ram.sv]
`default_nettype none

module g2l_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 200,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/g2l_alu.sv]
`default_nettype none

module g2l_alu (
    input  g2l_pkg::t_alu_req         i_req,
    input  g2l_pkg::t_terms           i_terms,
    input  logic [g2l_pkg::ACC_W-1:0] i_acc,
    output logic [g2l_pkg::ACC_W-1:0] o_res
);

    import g2l_pkg::*;

    logic [ACC_W-1:0] w_opnd;

    always_comb begin
        case (i_req.sel)
            SEL_P365: w_opnd = ACC_W'(i_terms.p365);
            SEL_YQ4:  w_opnd = ACC_W'(i_terms.ty >> 2);
            SEL_Q100: w_opnd = ACC_W'(i_terms.tq);
            SEL_Q400: w_opnd = ACC_W'(i_terms.tq >> 2);
            SEL_DOY:  w_opnd = ACC_W'(i_terms.doy);
            SEL_LEN:  w_opnd = ACC_W'(i_terms.len);
            default:  w_opnd = '0;
        endcase
        o_res = i_req.sub ? (i_acc - w_opnd) : (i_acc + w_opnd);
    end

endmodule

`default_nettype wire
